FILE: sv/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
package wsfd_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PROTO   = 2'd1,
    ST_OPCODE  = 2'd2,
    ST_TOO_BIG = 2'd3
  } wsfd_status_t;

  localparam logic [6:0] LEN_16 = 7'd126;
  localparam logic [6:0] LEN_64 = 7'd127;

  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [3:0] KO_SHORT = 4'd2;
  localparam logic [3:0] KO_16    = 4'd4;
  localparam logic [3:0] KO_64    = 4'd10;
  localparam logic [3:0] KEY_LEN  = 4'd4;
  localparam logic [3:0] HI_LEN_END = 4'd6;

  localparam logic [31:0] LIMIT_RESET = 32'd65536;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } wsfd_item_t;

  typedef struct packed {
    logic         has_payload;
    logic [7:0]   payload;
    logic         frame_end;
    wsfd_status_t status;
    logic [3:0]   opcode;
    logic         fin;
    logic [31:0]  length;
  } wsfd_res_t;

endpackage

FILE: sv/wsfd_in_stage.sv
// Input register stage: holds one request until the parser takes it.
module wsfd_in_stage
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  input  logic       take,
  output wsfd_item_t item
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_byte;
      last_r <= in_last_byte;
    end
  end

  assign item.valid = valid_r;
  assign item.data  = data_r;
  assign item.last  = last_r;

endmodule

FILE: sv/wsfd_parser.sv
// Frame header decode, payload unmask and end-of-message status.
module wsfd_parser
  import wsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  wsfd_item_t  item,
  input  logic        out_free,
  output logic        take,
  output logic        res_load,
  output wsfd_res_t   res
);

  logic [31:0]  limit_r;
  logic [7:0]   fhb_r, fhb_nxt;
  logic [3:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [32:0]  pay_cnt_r, pay_cnt_nxt;
  logic [31:0]  dl_r, dl_nxt;
  logic [6:0]   lc_r, lc_nxt;
  logic [31:0]  key_r, key_nxt;
  logic         hln_r, hln_nxt;
  wsfd_status_t hf_r, hf_nxt;

  logic [3:0]   ko, ko_nxt;
  logic [3:0]   op;
  logic         in_pay;
  logic         has;
  logic [7:0]   key_byte;
  logic         produce;
  wsfd_status_t st;

  always_comb begin
    ko = (lc_r == LEN_16) ? KO_16 : ((lc_r == LEN_64) ? KO_64 : KO_SHORT);
    fhb_nxt = fhb_r;
    dl_nxt  = dl_r;
    lc_nxt  = lc_r;
    key_nxt = key_r;
    hln_nxt = hln_r;
    hf_nxt  = hf_r;
    op      = fhb_r[3:0];
    in_pay  = 1'b0;
    has     = 1'b0;

    case (pay_cnt_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase

    if (hdr_cnt_r == 4'd0) begin
      fhb_nxt = item.data;
    end else if (hdr_cnt_r == 4'd1) begin
      lc_nxt = item.data[6:0];
      if (fhb_r[6:4] != 3'd0) begin
        hf_nxt = ST_PROTO;
      end else if (!(op <= OP_BINARY || (op >= OP_CLOSE && op <= OP_PONG))) begin
        hf_nxt = ST_OPCODE;
      end else if (!item.data[7]) begin
        hf_nxt = ST_PROTO;
      end else begin
        hf_nxt = ST_OK;
      end
      if (item.data[6:0] < LEN_16) begin
        dl_nxt = {25'd0, item.data[6:0]};
      end
    end else if (hdr_cnt_r < ko) begin
      if (lc_r == LEN_64 && hdr_cnt_r < HI_LEN_END) begin
        if (item.data != 8'd0) begin
          hln_nxt = 1'b1;
        end
      end else begin
        dl_nxt = {dl_r[23:0], item.data};
      end
    end else if (hdr_cnt_r < ko + KEY_LEN) begin
      key_nxt = {key_r[23:0], item.data};
    end else begin
      in_pay = 1'b1;
      if (hf_r == ST_OK && !hln_r && pay_cnt_r < {1'b0, dl_r}) begin
        has = 1'b1;
      end
    end

    hdr_cnt_nxt = (hdr_cnt_r == 4'hF) ? hdr_cnt_r : hdr_cnt_r + 4'd1;
    pay_cnt_nxt = (in_pay && pay_cnt_r != '1) ? pay_cnt_r + 33'd1 : pay_cnt_r;

    ko_nxt = (lc_nxt == LEN_16) ? KO_16 : ((lc_nxt == LEN_64) ? KO_64 : KO_SHORT);
    if (hdr_cnt_nxt < 4'd2) begin
      st = ST_PROTO;
    end else if (hf_nxt != ST_OK) begin
      st = hf_nxt;
    end else if (lc_nxt == LEN_16 && hdr_cnt_nxt < KO_16) begin
      st = ST_PROTO;
    end else if (lc_nxt == LEN_64 && hdr_cnt_nxt < KO_64) begin
      st = ST_PROTO;
    end else if (lc_nxt == LEN_64 && hln_nxt) begin
      st = ST_TOO_BIG;
    end else if (hdr_cnt_nxt < ko_nxt + KEY_LEN) begin
      st = ST_PROTO;
    end else if (pay_cnt_nxt != {1'b0, dl_nxt}) begin
      st = ST_PROTO;
    end else if (dl_nxt >= limit_r) begin
      st = ST_TOO_BIG;
    end else begin
      st = ST_OK;
    end
  end

  assign produce  = has || item.last;
  assign take     = item.valid && (!produce || out_free);
  assign res_load = take && produce;

  assign res.has_payload = has;
  assign res.payload     = has ? (item.data ^ key_byte) : 8'd0;
  assign res.frame_end   = item.last;
  assign res.status      = item.last ? st : ST_OK;
  assign res.opcode      = item.last ? fhb_nxt[3:0] : 4'd0;
  assign res.fin         = item.last ? fhb_nxt[7] : 1'b0;
  assign res.length      = item.last ? dl_nxt : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fhb_r     <= 8'd0;
      hdr_cnt_r <= 4'd0;
      pay_cnt_r <= 33'd0;
      dl_r      <= 32'd0;
      lc_r      <= 7'd0;
      key_r     <= 32'd0;
      hln_r     <= 1'b0;
      hf_r      <= ST_OK;
    end else if (take) begin
      if (item.last) begin
        fhb_r     <= 8'd0;
        hdr_cnt_r <= 4'd0;
        pay_cnt_r <= 33'd0;
        dl_r      <= 32'd0;
        lc_r      <= 7'd0;
        key_r     <= 32'd0;
        hln_r     <= 1'b0;
        hf_r      <= ST_OK;
      end else begin
        fhb_r     <= fhb_nxt;
        hdr_cnt_r <= hdr_cnt_nxt;
        pay_cnt_r <= pay_cnt_nxt;
        dl_r      <= dl_nxt;
        lc_r      <= lc_nxt;
        key_r     <= key_nxt;
        hln_r     <= hln_nxt;
        hf_r      <= hf_nxt;
      end
    end
  end

  a_no_fault_too_big: assert property (@(posedge clk) disable iff (!rst_n)
    hf_r != ST_TOO_BIG)
    else $error("header fault holds the too-big code");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.last |=> hdr_cnt_r == 4'd0 && pay_cnt_r == 33'd0)
    else $error("frame state not cleared after last byte");

  a_payload_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res.has_payload |-> hdr_cnt_r >= KO_SHORT + KEY_LEN && hf_r == ST_OK)
    else $error("payload emitted before header and key complete");

  a_pay_cnt_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    pay_cnt_r != 33'd0 |-> hdr_cnt_r >= KO_SHORT + KEY_LEN)
    else $error("payload count advanced inside header");

endmodule

FILE: sv/wsfd_out_reg.sv
// Result register: holds one result until the receiver takes it.
module wsfd_out_reg
  import wsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_load,
  input  wsfd_res_t   res,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_payload,
  output logic [7:0]  out_payload_out,
  output logic        out_frame_end,
  output logic [1:0]  out_status,
  output logic [3:0]  out_frame_opcode,
  output logic        out_frame_fin,
  output logic [31:0] out_frame_length
);

  logic      valid_r, valid_nxt;
  wsfd_res_t res_r;

  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = res_load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_has_payload  = res_r.has_payload;
  assign out_payload_out  = res_r.payload;
  assign out_frame_end    = res_r.frame_end;
  assign out_status       = res_r.status;
  assign out_frame_opcode = res_r.opcode;
  assign out_frame_fin    = res_r.fin;
  assign out_frame_length = res_r.length;

endmodule

FILE: sv/websocket_frame_decode_unmask.sv
// Top level of the server-side WebSocket frame decoder and unmasker.
//
// Input channel: one raw message byte per request (in_byte), with
// in_last_byte marking the final byte of the message. The message holds one
// frame. Result channel: one request per payload byte (out_has_payload,
// out_payload_out unmasked) and one at the last byte (out_frame_end with
// out_status, out_frame_opcode, out_frame_fin, out_frame_length); header
// bytes give no result. cfg_wr_en writes the payload limit from cfg_wr_data;
// the user must do it only while the block is idle; no check enforces this.
// A byte taken into the input register is decoded there by the parser and
// its result is loaded into the output register unless a stalled result
// there holds it back in the input register.
// Throughput: one byte per cycle unless the receiver stalls a full result
// register, set by the header/unmask update of the parser state per byte.
// Reset (rst_n low at a clock edge) empties both registers, clears the frame
// state and sets the limit to 65536.
// When the receiver stalls, the result register holds; bytes that produce no
// result still pass, and the first byte that needs the result register
// waits in the input register, which then stalls the sender.
module websocket_frame_decode_unmask
  import wsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_payload,
  output logic [7:0]  out_payload_out,
  output logic        out_frame_end,
  output logic [1:0]  out_status,
  output logic [3:0]  out_frame_opcode,
  output logic        out_frame_fin,
  output logic [31:0] out_frame_length
);

  wsfd_item_t item;
  wsfd_res_t  res;
  logic       take;
  logic       res_load;
  logic       out_free;

  wsfd_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .take         (take),
    .item         (item)
  );

  wsfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .out_free    (out_free),
    .take        (take),
    .res_load    (res_load),
    .res         (res)
  );

  wsfd_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_load         (res_load),
    .res              (res),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_has_payload  (out_has_payload),
    .out_payload_out  (out_payload_out),
    .out_frame_end    (out_frame_end),
    .out_status       (out_status),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_fin    (out_frame_fin),
    .out_frame_length (out_frame_length)
  );

endmodule

FILE: sim/tb_websocket_frame_decode_unmask.sv
// Self-checking testbench for the server-side WebSocket frame decoder and unmasker.
`timescale 1ns / 1ps

module tb_websocket_frame_decode_unmask;
  import wsfd_pkg::*;

  localparam logic [3:0] OP_CONT = 4'd0;
  localparam logic [3:0] OP_TEXT = 4'd1;
  localparam logic [3:0] OP_PING = 4'd9;
  localparam logic [33:0] POS_SAT = '1;
  localparam int SEG_BYTES = 255;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    wsfd_res_t  res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_has_payload;
  logic [7:0]  out_payload_out;
  logic        out_frame_end;
  logic [1:0]  out_status;
  logic [3:0]  out_frame_opcode;
  logic        out_frame_fin;
  logic [31:0] out_frame_length;

  websocket_frame_decode_unmask dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_has_payload  (out_has_payload),
    .out_payload_out  (out_payload_out),
    .out_frame_end    (out_frame_end),
    .out_status       (out_status),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_fin    (out_frame_fin),
    .out_frame_length (out_frame_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder state mirror
  logic [7:0]   hdr0;
  logic [33:0]  pos;
  logic [31:0]  decl_len;
  logic [6:0]   len_code;
  logic [31:0]  mask_key;
  bit           hi_len_nz;
  wsfd_status_t fault;
  logic [31:0]  limit_q = LIMIT_RESET;

  wsfd_res_t decoded_q [$];
  dir_row_t  dir_tbl [$];
  int        bad_results = 0;
  int        bytes_sent = 0;
  int        send_idle_pct = 19;
  int        stall_pct = 55;
  logic [3:0] good_ops [6] = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};

  task automatic clear_frame();
    hdr0 = '0;
    pos = '0;
    decl_len = '0;
    len_code = '0;
    mask_key = '0;
    hi_len_nz = 1'b0;
    fault = ST_OK;
  endtask

  function automatic logic [33:0] key_offset();
    if (len_code == LEN_16) return 34'(KO_16);
    if (len_code == LEN_64) return 34'(KO_64);
    return 34'(KO_SHORT);
  endfunction

  function automatic wsfd_status_t frame_status(input logic [33:0] count);
    if (count < KO_SHORT) return ST_PROTO;
    if (fault != ST_OK) return fault;
    if (len_code == LEN_16 && count < KO_16) return ST_PROTO;
    if (len_code == LEN_64) begin
      if (count < KO_64) return ST_PROTO;
      if (hi_len_nz) return ST_TOO_BIG;
    end
    if (count != {2'b00, decl_len} + key_offset() + KEY_LEN) return ST_PROTO;
    if (decl_len >= limit_q) return ST_TOO_BIG;
    return ST_OK;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last,
                             output bit produced, output wsfd_res_t res);
    logic [33:0] ko;
    logic [33:0] idx;
    logic [3:0]  op;
    res = '0;
    if (pos == 0) begin
      hdr0 = b;
    end else if (pos == 1) begin
      op = hdr0[3:0];
      len_code = b[6:0];
      if (hdr0[6:4] != 3'b000) fault = ST_PROTO;
      else if (!(op <= OP_BINARY || (op >= OP_CLOSE && op <= OP_PONG))) fault = ST_OPCODE;
      else if (!b[7]) fault = ST_PROTO;
      else fault = ST_OK;
      if (len_code < LEN_16) decl_len = 32'(len_code);
    end else begin
      ko = key_offset();
      if (pos < ko) begin
        if (len_code == LEN_64 && pos < HI_LEN_END) begin
          if (b != 8'h00) hi_len_nz = 1'b1;
        end else begin
          decl_len = {decl_len[23:0], b};
        end
      end else if (pos < ko + KEY_LEN) begin
        mask_key = {mask_key[23:0], b};
      end else begin
        idx = pos - ko - KEY_LEN;
        if (fault == ST_OK && !hi_len_nz && idx < {2'b00, decl_len}) begin
          res.has_payload = 1'b1;
          res.payload = b ^ mask_key[8 * (3 - int'(idx[1:0])) +: 8];
        end
      end
    end
    if (pos != POS_SAT) pos = pos + 1'b1;
    produced = res.has_payload || last;
    if (last) begin
      res.frame_end = 1'b1;
      res.status = frame_status(pos);
      res.opcode = hdr0[3:0];
      res.fin = hdr0[7];
      res.length = decl_len;
      clear_frame();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last,
                           input bit typed, input wsfd_res_t typed_res);
    bit        produced;
    wsfd_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    decode_byte(b, last, produced, res);
    if (produced) decoded_q.push_back(typed ? typed_res : res);
    bytes_sent++;
  endtask

  // hold the sender until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  task automatic write_limit(input logic [31:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_q = value;
  endtask

  task automatic add_row(input logic [7:0] d);
    dir_tbl.push_back('{d, 1'b0, 1'b0, '0});
  endtask

  task automatic add_end(input logic [7:0] d, input wsfd_res_t r);
    dir_tbl.push_back('{d, 1'b1, 1'b1, r});
  endtask

  task automatic send_message();
    logic [7:0]  msg [$];
    logic [31:0] plen;
    int          kind;
    int          form;
    int          pick;
    kind = $urandom_range(99);
    if (kind < 82) begin
      plen = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 0);
      pick = $urandom_range(19);
      form = (pick < 14) ? 0 : (pick < 17) ? 1 : 2;
      if (plen >= LEN_16 && form == 0) form = 1;
      msg.push_back({1'($urandom), 3'b000, good_ops[$urandom_range(5)]});
      case (form)
        0: msg.push_back({1'b1, plen[6:0]});
        1: begin
          msg.push_back({1'b1, LEN_16});
          msg.push_back(plen[15:8]);
          msg.push_back(plen[7:0]);
        end
        default: begin
          msg.push_back({1'b1, LEN_64});
          repeat (4) msg.push_back(8'h00);
          for (int i = 3; i >= 0; i--) msg.push_back(plen[8 * i +: 8]);
        end
      endcase
      repeat (4) msg.push_back(8'($urandom));
      repeat (plen) msg.push_back(8'($urandom));
      if (kind >= 70) begin
        msg[0] = 8'($urandom);
        msg[1][7] = 1'($urandom);
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
        repeat ($urandom_range(3, 1)) msg.push_back(8'($urandom));
      end else if (pick == 1) begin
        repeat ($urandom_range(3, 1)) if (msg.size() > 1) void'(msg.pop_back());
      end
    end else if (kind < 90) begin
      msg.push_back({1'($urandom), 3'b000, good_ops[$urandom_range(5)]});
      msg.push_back({1'b1, LEN_64});
      repeat (4) msg.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
      plen = $urandom_range(1) ? $urandom : $urandom_range(8);
      for (int i = 3; i >= 0; i--) msg.push_back(plen[8 * i +: 8]);
      repeat (4) msg.push_back(8'($urandom));
      repeat ($urandom_range(8)) msg.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(12, 1)) msg.push_back(8'($urandom));
    end
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
  endtask

  always @(posedge clk) begin : check_results
    wsfd_res_t want;
    wsfd_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_has_payload, out_payload_out, out_frame_end, out_status,
             out_frame_opcode, out_frame_fin, out_frame_length};
      if (decoded_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: has=%0d data=%02h end=%0d st=%0d op=%0h fin=%0d len=%0d",
                   got.has_payload, got.payload, got.frame_end, got.status, got.opcode,
                   got.fin, got.length);
      end else begin
        want = decoded_q.pop_front();
        if (got.has_payload !== want.has_payload || got.payload !== want.payload ||
            got.frame_end !== want.frame_end || got.status !== want.status ||
            got.opcode !== want.opcode || got.fin !== want.fin ||
            got.length !== want.length) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("expected has=%0d data=%02h end=%0d st=%0d op=%0h fin=%0d len=%0d",
                     want.has_payload, want.payload, want.frame_end, want.status,
                     want.opcode, want.fin, want.length);
            $display("  actual has=%0d data=%02h end=%0d st=%0d op=%0h fin=%0d len=%0d",
                     got.has_payload, got.payload, got.frame_end, got.status,
                     got.opcode, got.fin, got.length);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int seg_start;
    clear_frame();

    // one-byte message
    add_end(8'h81, '{1'b0, 8'h00, 1'b1, ST_PROTO, 4'h1, 1'b1, 32'd0});
    // masked text frame, one payload byte
    add_row(8'h81);
    add_row(8'h81);
    add_row(8'hFF);
    add_row(8'h00);
    add_row(8'hA5);
    add_row(8'h5A);
    add_end(8'hFF, '{1'b1, 8'h00, 1'b1, ST_OK, 4'h1, 1'b1, 32'd1});
    // reserved bits set
    add_row(8'hF2);
    add_end(8'h80, '{1'b0, 8'h00, 1'b1, ST_PROTO, OP_BINARY, 1'b1, 32'd0});
    // unsupported opcode
    add_row(8'h0F);
    add_end(8'hFF, '{1'b0, 8'h00, 1'b1, ST_OPCODE, 4'hF, 1'b0, 32'd0});
    // unmasked frame
    add_row(8'h89);
    add_end(8'h00, '{1'b0, 8'h00, 1'b1, ST_PROTO, OP_PING, 1'b1, 32'd0});
    // 64-bit length with a nonzero upper half
    add_row(8'h82);
    add_row(8'hFF);
    add_row(8'h01);
    repeat (3) add_row(8'h00);
    repeat (3) add_row(8'hFF);
    add_end(8'hFF, '{1'b0, 8'h00, 1'b1, ST_TOO_BIG, OP_BINARY, 1'b1, 32'hFFFF_FFFF});
    // 16-bit length cut short
    add_row(8'h8A);
    add_row(8'hFE);
    add_end(8'h00, '{1'b0, 8'h00, 1'b1, ST_PROTO, OP_PONG, 1'b1, 32'd0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) send_byte(dir_tbl[i].data, dir_tbl[i].last, dir_tbl[i].typed,
                                   dir_tbl[i].res);

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 55;
        stall_pct = 19;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      case (seg)
        1: write_limit(32'd1);
        2: write_limit(32'hFFFF_FFFF);
        3: write_limit(32'd0);
        4: write_limit(32'($urandom_range(64, 2)));
        5: write_limit(LIMIT_RESET);
        default: ;
      endcase
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SEG_BYTES) begin
        send_message();
        if ($urandom_range(39) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (bad_results == 0 && decoded_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
